>>> rtl/rqpa_pkg.sv
// shared constants, types and helpers for the ring queue pop average block
package rqpa_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 11;
  localparam int POP_W     = 12;
  localparam int STAT_W    = 3;
  localparam int SUM_W     = WORD_BITS + POP_W;
  localparam int CMP_W     = 18;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_PUSHED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL_AVG = 3'd2;
  localparam logic [STAT_W-1:0] ST_PART_AVG = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DRAIN,
    S_DIV
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [POP_W-1:0]        divisor;
  } div_req_t;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] c;
    c = cap;
    if (c == '0) c = CAP_W'(1);
    if (CMP_W'(c) > CMP_W'(DEPTH)) c = CAP_W'(DEPTH);
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx,
                                                input logic [CAP_W-1:0]  cap);
    logic [ADDR_W:0] n;
    n = {1'b0, idx} + (ADDR_W+1)'(1);
    if (CMP_W'(n) >= CMP_W'(cap) || CMP_W'(n) >= CMP_W'(DEPTH)) n = '0;
    return n[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/rqpa_ram.sv
// generic single write port ram with registered read
module rqpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rqpa_div.sv
// bit serial signed by unsigned divider, quotient truncated toward zero
module rqpa_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rqpa_pkg::div_req_t              req,
  output logic                            done,
  output logic [rqpa_pkg::WORD_BITS-1:0]  quotient
);
  import rqpa_pkg::*;

  localparam int CNT_BITS = $clog2(SUM_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [POP_W-1:0]    rem_r, rem_nxt;
  logic [POP_W-1:0]    dvs_r, dvs_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [POP_W:0]      rem_sh;
  logic                ge;
  logic [SUM_W-1:0]    quo_signed;

  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(SUM_W);
      neg_nxt  = req.dividend[SUM_W-1];
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    end else if (busy_r) begin
      rem_nxt = ge ? POP_W'(rem_sh - {1'b0, dvs_r}) : POP_W'(rem_sh);
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quo_signed = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;
  assign quotient   = quo_signed[WORD_BITS-1:0];
  assign done       = done_r;

endmodule

>>> rtl/ring_queue_pop_average.sv
// top level: circular queue with capacity register, pop and average control
//
// A push's result beat appears in the cycle after it is accepted; pushes can
// be issued back to back. A pop of k values, once accepted, holds busy high
// until its result beat, which shows in the first cycle with busy low again.
// The pop makes one read of the ring memory per value (one read port), lets the
// last read land, runs a bit serial divide of 44 steps and takes the quotient.
// A pop that finds nothing to take, or asks for zero values, answers like a
// push. busy is high while a pop is in progress; each result beat is shown on
// the out_ ports for exactly one cycle with out_valid high and cannot be held
// off. The capacity may be written through the cfg_ port at any time the block
// is idle; cfg_ready is always high.
module ring_queue_pop_average (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_mode,
  input  logic signed [rqpa_pkg::WORD_BITS-1:0] in_value,
  input  logic [rqpa_pkg::POP_W-1:0]         in_pop_count,
  output logic                               out_valid,
  output logic [rqpa_pkg::STAT_W-1:0]        out_status,
  output logic signed [rqpa_pkg::WORD_BITS-1:0] out_average,
  output logic [rqpa_pkg::POP_W-1:0]         out_popped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rqpa_pkg::CAP_W-1:0]         cfg_capacity
);
  import rqpa_pkg::*;

  state_t                state_r, state_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic [CAP_W-1:0]      cap;
  logic [ADDR_W-1:0]     head_r, head_nxt;
  logic [ADDR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [POP_W-1:0]      npop_r, npop_nxt;
  logic [POP_W-1:0]      issued_r, issued_nxt;
  logic                  ran_out_r, ran_out_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                  rd_vld_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [WORD_BITS-1:0]  out_average_r, out_average_nxt;
  logic [POP_W-1:0]      out_popped_r, out_popped_nxt;

  logic                  accept;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic                  re;
  logic [WORD_BITS-1:0]  rdata;
  logic [ADDR_W-1:0]     push_base;
  logic                  want_gt_fill;
  logic [POP_W-1:0]      npop_calc;
  div_req_t              div_req;
  logic                  div_done;
  logic [WORD_BITS-1:0]  div_quot;

  assign cap          = eff_cap(cap_r);
  assign accept       = start && (state_r == S_IDLE);
  assign push_base    = (fill_r == '0) ? '0 : tail_r;
  assign want_gt_fill = CMP_W'(in_pop_count) > CMP_W'(fill_r);
  assign npop_calc    = want_gt_fill ? POP_W'(fill_r) : in_pop_count;

  rqpa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_value),
    .re   (re),
    .raddr(head_r),
    .rdata(rdata)
  );

  rqpa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_POP && npop_calc != '0) state_nxt = S_POP;
      end
      S_POP: begin
        if (issued_r + POP_W'(1) == npop_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    fill_nxt        = fill_r;
    npop_nxt        = npop_r;
    issued_nxt      = issued_r;
    ran_out_nxt     = ran_out_r;
    sum_nxt         = rd_vld_r ? sum_r + SUM_W'(signed'(rdata)) : sum_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_average_nxt = out_average_r;
    out_popped_nxt  = out_popped_r;
    we              = 1'b0;
    waddr           = push_base;
    re              = 1'b0;
    div_req         = '{start: 1'b0, dividend: sum_nxt, divisor: npop_r};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = '0;
          out_popped_nxt  = '0;
          if (in_mode == MODE_PUSH) begin
            if (CMP_W'(fill_r) >= CMP_W'(cap)) begin
              out_status_nxt = ST_OVERFLOW;
            end else begin
              we             = 1'b1;
              tail_nxt       = advance(push_base, cap);
              head_nxt       = (fill_r == '0) ? '0 : head_r;
              fill_nxt       = fill_r + CNT_W'(1);
              out_status_nxt = ST_PUSHED;
            end
          end else begin
            npop_nxt    = npop_calc;
            ran_out_nxt = want_gt_fill;
            issued_nxt  = '0;
            sum_nxt     = '0;
            if (npop_calc != '0) begin
              out_valid_nxt = 1'b0;
            end else begin
              out_status_nxt = want_gt_fill ? ST_EMPTY : ST_FULL_AVG;
            end
          end
        end
      end
      S_POP: begin
        re         = 1'b1;
        head_nxt   = advance(head_r, cap);
        fill_nxt   = fill_r - CNT_W'(1);
        issued_nxt = issued_r + POP_W'(1);
      end
      S_DRAIN: begin
        div_req.start = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ran_out_r ? ST_PART_AVG : ST_FULL_AVG;
          out_average_nxt = div_quot;
          out_popped_nxt  = npop_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= re;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
    npop_r        <= npop_nxt;
    issued_r      <= issued_nxt;
    ran_out_r     <= ran_out_nxt;
    sum_r         <= sum_nxt;
    out_status_r  <= out_status_nxt;
    out_average_r <= out_average_nxt;
    out_popped_r  <= out_popped_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_average = signed'(out_average_r);
  assign out_popped  = out_popped_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= CMP_W'(DEPTH))
    else $error("fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (fill_r != '0))
    else $error("pop read from empty queue");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide wait");

  a_push_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_PUSHED || out_status_r == ST_OVERFLOW))
      |-> (out_popped_r == '0))
    else $error("push beat reports popped values");
`endif

endmodule

>>> dv/tb.sv
// testbench for ring_queue_pop_average: random push/pop beats checked against a queue mirror
`timescale 1ns / 1ps

module tb;
  import rqpa_pkg::*;

  typedef struct {
    logic [STAT_W-1:0]           status;
    logic signed [WORD_BITS-1:0] average;
    logic [POP_W-1:0]            popped;
  } pop_result_t;

  class queue_mirror;
    logic signed [WORD_BITS-1:0] ring [DEPTH];
    bit                          written [DEPTH];
    int unsigned                 head;
    int unsigned                 tail;
    int unsigned                 fill;
    logic [CAP_W-1:0]            cap_reg;
    pop_result_t                 expected_q[$];
    int                          errors;

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      cap_reg = CAP_RESET;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int unsigned eff_limit(input logic [CAP_W-1:0] c);
      if (c == '0) return 1;
      if (int'(c) > DEPTH) return DEPTH;
      return int'(c);
    endfunction

    function int unsigned next_slot(input int unsigned idx, input int unsigned lim);
      int unsigned n;
      n = idx + 1;
      if (n >= lim || n >= DEPTH) n = 0;
      return n;
    endfunction

    // every slot below lim has been written at least once
    function bit all_written(input int unsigned lim);
      for (int unsigned i = 0; i < lim; i++) begin
        if (!written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void accept_item(input logic m, input logic signed [WORD_BITS-1:0] v,
                              input logic [POP_W-1:0] n);
      int unsigned lim;
      int unsigned taken;
      bit          ran_out;
      longint      total;
      pop_result_t r;
      lim = eff_limit(cap_reg);
      r.status = ST_PUSHED;
      r.average = '0;
      r.popped = '0;
      if (m == MODE_PUSH) begin
        if (fill >= lim) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (fill == 0) begin
            head = 0;
            tail = 0;
          end
          ring[tail] = v;
          written[tail] = 1'b1;
          tail = next_slot(tail, lim);
          fill++;
        end
      end else begin
        total = 0;
        taken = 0;
        ran_out = 1'b0;
        while (taken < n) begin
          if (fill == 0) begin
            ran_out = 1'b1;
            break;
          end
          total += ring[head];
          head = next_slot(head, lim);
          fill--;
          taken++;
        end
        if (taken == 0) begin
          r.status = ran_out ? ST_EMPTY : ST_FULL_AVG;
        end else begin
          r.average = WORD_BITS'(total / longint'(taken));
          r.status = ran_out ? ST_PART_AVG : ST_FULL_AVG;
        end
        r.popped = POP_W'(taken);
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_beat(input logic [STAT_W-1:0] st,
                             input logic signed [WORD_BITS-1:0] avg,
                             input logic [POP_W-1:0] cnt);
      pop_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat status %0d average %0d popped %0d", $time, st, avg, cnt);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (st !== e.status) begin
        $display("%0t status mismatch exp %0d got %0d", $time, e.status, st);
        errors++;
      end
      if (avg !== e.average) begin
        $display("%0t average mismatch exp %0d got %0d", $time, e.average, avg);
        errors++;
      end
      if (cnt !== e.popped) begin
        $display("%0t popped mismatch exp %0d got %0d", $time, e.popped, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_mode;
  logic signed [WORD_BITS-1:0] in_value;
  logic [POP_W-1:0]            in_pop_count;
  logic                        out_valid;
  logic [STAT_W-1:0]           out_status;
  logic signed [WORD_BITS-1:0] out_average;
  logic [POP_W-1:0]            out_popped;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CAP_W-1:0]            cfg_capacity;

  queue_mirror mirror = new();
  int          issued = 0;
  bit          no_gaps = 1'b0;

  ring_queue_pop_average dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .in_pop_count (in_pop_count),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_average  (out_average),
    .out_popped   (out_popped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) mirror.check_beat(out_status, out_average, out_popped);
  end

  function automatic logic signed [WORD_BITS-1:0] rand_word();
    case ($urandom_range(7))
      0: return {1'b0, {(WORD_BITS-1){1'b1}}};
      1: return {1'b1, {(WORD_BITS-1){1'b0}}};
      2: return WORD_BITS'(int'($urandom_range(200)) - 100);
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(11))
      0: return CAP_W'(0);
      1: return CAP_W'(1);
      2: return CAP_W'(2);
      3: return CAP_W'(3);
      4: return CAP_W'(5);
      5: return CAP_W'(8);
      6: return CAP_W'(16);
      7: return CAP_W'(64);
      8: return CAP_W'(DEPTH);
      9: return CAP_W'(DEPTH + 1);
      10: return {CAP_W{1'b1}};
      default: return CAP_W'($urandom_range(0, (1 << CAP_W) - 1));
    endcase
  endfunction

  task automatic issue(input logic m, input logic signed [WORD_BITS-1:0] v,
                       input logic [POP_W-1:0] n);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_value <= v;
    in_pop_count <= n;
    do @(posedge clk); while (busy);
    mirror.accept_item(m, v, n);
    issued++;
  endtask

  task automatic push_word(input logic signed [WORD_BITS-1:0] v);
    issue(MODE_PUSH, v, POP_W'($urandom));
  endtask

  task automatic pop_words(input logic [POP_W-1:0] n);
    issue(MODE_POP, rand_word(), n);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] c);
    drain();
    // empty first unless every slot below the new limit has been written
    if (mirror.fill != 0 && !mirror.all_written(mirror.eff_limit(c))) begin
      pop_words(POP_W'(DEPTH));
      drain();
    end
    cfg_valid <= 1'b1;
    cfg_capacity <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.cap_reg = c;
  endtask

  initial begin
    int unsigned push_pct;
    logic [POP_W-1:0] n;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_PUSH;
    in_value = '0;
    in_pop_count = '0;
    cfg_valid = 1'b0;
    cfg_capacity = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, zero count, extremes, truncation, partial pop
    pop_words(POP_W'(1));
    pop_words('0);
    push_word({1'b0, {(WORD_BITS-1){1'b1}}});
    push_word({1'b0, {(WORD_BITS-1){1'b1}}});
    pop_words(POP_W'(2));
    push_word({1'b1, {(WORD_BITS-1){1'b0}}});
    push_word({1'b1, {(WORD_BITS-1){1'b0}}});
    pop_words(POP_W'(2));
    push_word(-5);
    push_word(2);
    pop_words(POP_W'(2));
    push_word(7);
    push_word(0);
    pop_words({POP_W{1'b1}});
    push_word(5);
    pop_words('0);
    pop_words(POP_W'(1));

    // zero capacity behaves as one
    write_cap('0);
    push_word(1);
    push_word(2);
    pop_words(POP_W'(1));

    // shrink capacity while entries are held
    write_cap(CAP_W'(4));
    push_word(11);
    push_word(22);
    push_word(33);
    pop_words(POP_W'(1));
    write_cap(CAP_W'(2));
    pop_words(POP_W'(2));
    push_word(44);
    pop_words(POP_W'(1));

    while (issued < 850) begin
      write_cap(pick_cap());
      no_gaps = ($urandom_range(3) == 0);
      push_pct = $urandom_range(35, 70);
      repeat ($urandom_range(20, 80)) begin
        if ($urandom_range(99) < push_pct) begin
          push_word(rand_word());
        end else begin
          case ($urandom_range(19))
            0: n = '0;
            1, 2: n = POP_W'($urandom);
            default: n = POP_W'($urandom_range(1, mirror.fill + 2));
          endcase
          pop_words(n);
        end
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/rqpa_pkg.sv
rtl/rqpa_ram.sv
rtl/rqpa_div.sv
rtl/ring_queue_pop_average.sv
dv/tb.sv
